/* rtl/bfc_pkg.sv */
// Shared constants for the box frustum cull test.
// No dependencies; imported by bfc_corner_test and box_frustum_cull_test.
package bfc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int NUM_CFG_REGS = 8;
  localparam int CFG_IDX_W    = 4;
  localparam int WORD_W       = 64;
  localparam int HALF_W       = 32;

  localparam int NUM_AXES     = 3;
  localparam int NUM_ROWS     = 4;
  localparam int NUM_CORNERS  = 8;

endpackage

/* rtl/bfc_corner_test.sv */
// Corner projection and clip-plane tests: three register stages.
// Depends on bfc_pkg; instantiated by box_frustum_cull_test.
module bfc_corner_test #(
  parameter int COORD_WIDTH = bfc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = bfc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] cm_i  [bfc_pkg::NUM_ROWS][bfc_pkg::NUM_ROWS],
  input  logic signed [COORD_WIDTH-1:0] pos_i [bfc_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] neg_i [bfc_pkg::NUM_AXES],
  output logic                          valid_o,
  output logic                          visible_o,
  output logic                          near_plane_hit_o
);
  import bfc_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int PW   = 2 * W;
  localparam int SW   = 2 * W + 2;
  localparam int CW   = 2 * W + 3;

  logic signed [W-1:0]  crn       [NUM_CORNERS][NUM_AXES];
  logic signed [PW-1:0] prod_d    [NUM_CORNERS][NUM_ROWS][NUM_AXES];
  logic signed [PW-1:0] prod_q    [NUM_CORNERS][NUM_ROWS][NUM_AXES];
  logic signed [W-1:0]  cm3_q     [NUM_ROWS];
  logic signed [CW-1:0] clip_d    [NUM_CORNERS][NUM_ROWS];
  logic signed [CW-1:0] clip_q    [NUM_CORNERS][NUM_ROWS];
  logic [1:0]           valid_q;
  logic                 out_valid_q;
  logic                 visible_q;
  logic                 hit_q;
  logic                 hit_d;
  logic                 visible_d;

  always_comb begin
    for (int n = 0; n < NUM_CORNERS; n++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        crn[n][k] = ((n >> k) & 1) != 0 ? neg_i[k] : pos_i[k];
      end
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          prod_d[n][r][k] = cm_i[r][k] * crn[n][k];
        end
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] sh;
    acc = '0;
    sh  = '0;
    for (int n = 0; n < NUM_CORNERS; n++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        acc = SW'(prod_q[n][r][0]) + SW'(prod_q[n][r][1]) + SW'(prod_q[n][r][2]);
        sh  = acc >>> FRAC_BITS;
        clip_d[n][r] = CW'(sh) + CW'(cm3_q[r]);
      end
    end
  end

  always_comb begin
    logic signed [CW:0] w_pos;
    logic signed [CW:0] w_neg;
    logic all_xp, all_xn, all_yp, all_yn, all_zp, all_zn;
    hit_d  = 1'b0;
    all_xp = 1'b1;
    all_xn = 1'b1;
    all_yp = 1'b1;
    all_yn = 1'b1;
    all_zp = 1'b1;
    all_zn = 1'b1;
    w_pos  = '0;
    w_neg  = '0;
    for (int n = 0; n < NUM_CORNERS; n++) begin
      w_pos = (CW+1)'(clip_q[n][3]);
      w_neg = -w_pos;
      if (w_pos <= 0) hit_d = 1'b1;
      if (!((CW+1)'(clip_q[n][0]) > w_pos)) all_xp = 1'b0;
      if (!((CW+1)'(clip_q[n][0]) < w_neg)) all_xn = 1'b0;
      if (!((CW+1)'(clip_q[n][1]) > w_pos)) all_yp = 1'b0;
      if (!((CW+1)'(clip_q[n][1]) < w_neg)) all_yn = 1'b0;
      if (!((CW+1)'(clip_q[n][2]) > w_pos)) all_zp = 1'b0;
      if (!clip_q[n][2][CW-1]) all_zn = 1'b0;
    end
    visible_d = hit_d | ~(all_xp | all_xn | all_yp | all_yn | all_zp | all_zn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= {valid_q[0], valid_i};
      out_valid_q <= valid_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    for (int r = 0; r < NUM_ROWS; r++) begin
      cm3_q[r] <= cm_i[r][3];
    end
    clip_q    <= clip_d;
    visible_q <= visible_d;
    hit_q     <= hit_d;
  end

  assign valid_o          = out_valid_q;
  assign visible_o        = visible_q;
  assign near_plane_hit_o = hit_q;

endmodule

/* rtl/box_frustum_cull_test.sv */
// Top level of the box frustum cull test: configuration registers and matrix product.
// Depends on bfc_pkg and bfc_corner_test.
//
// Fully pipelined: one object is taken every clock cycle (busy is always low) and its
// result appears on result_valid_o for a single cycle. There are three stages of the
// 4x4 matrix product (multiply, sum, round and saturate), then three stages of corner
// projection and plane tests. The receiver cannot stall. Configuration writes are
// taken at once; the user must write only while idle; the block does not enforce it.
module box_frustum_cull_test #(
  parameter int COORD_WIDTH = bfc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = bfc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [bfc_pkg::WORD_W-1:0]     model_c0_r01_i,
  input  logic [bfc_pkg::WORD_W-1:0]     model_c0_r23_i,
  input  logic [bfc_pkg::WORD_W-1:0]     model_c1_r01_i,
  input  logic [bfc_pkg::WORD_W-1:0]     model_c1_r23_i,
  input  logic [bfc_pkg::WORD_W-1:0]     model_c2_r01_i,
  input  logic [bfc_pkg::WORD_W-1:0]     model_c2_r23_i,
  input  logic [bfc_pkg::WORD_W-1:0]     model_c3_r01_i,
  input  logic [bfc_pkg::WORD_W-1:0]     model_c3_r23_i,
  input  logic [bfc_pkg::WORD_W-1:0]     origin_xy_i,
  input  logic [bfc_pkg::WORD_W-1:0]     origin_z_extent_x_i,
  input  logic [bfc_pkg::WORD_W-1:0]     extent_yz_i,
  output logic                           result_valid_o,
  output logic                           visible_o,
  output logic                           near_plane_hit_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfc_pkg::WORD_W-1:0]     cfg_data_i
);
  import bfc_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 2;

  logic [WORD_W-1:0]    vp_q   [NUM_CFG_REGS];
  logic [WORD_W-1:0]    mw     [NUM_CFG_REGS];
  logic signed [W-1:0]  vp     [NUM_ROWS][NUM_ROWS];
  logic signed [W-1:0]  md     [NUM_ROWS][NUM_ROWS];
  logic signed [W-1:0]  org    [NUM_AXES];
  logic signed [W-1:0]  ext    [NUM_AXES];
  logic signed [W-1:0]  pos_d  [NUM_AXES];
  logic signed [W-1:0]  neg_d  [NUM_AXES];
  logic signed [W-1:0]  pos_q  [3][NUM_AXES];
  logic signed [W-1:0]  neg_q  [3][NUM_AXES];
  logic signed [PW-1:0] prod_d [NUM_ROWS][NUM_ROWS][NUM_ROWS];
  logic signed [PW-1:0] prod_q [NUM_ROWS][NUM_ROWS][NUM_ROWS];
  logic signed [SW-1:0] sum_d  [NUM_ROWS][NUM_ROWS];
  logic signed [SW-1:0] sum_q  [NUM_ROWS][NUM_ROWS];
  logic signed [W-1:0]  cm_d   [NUM_ROWS][NUM_ROWS];
  logic signed [W-1:0]  cm_q   [NUM_ROWS][NUM_ROWS];
  logic [2:0]           valid_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG_REGS; i++) begin
        vp_q[i] <= '0;
      end
    end else if (cfg_valid_i && (int'(cfg_index_i) < NUM_CFG_REGS)) begin
      vp_q[cfg_index_i[$clog2(NUM_CFG_REGS)-1:0]] <= cfg_data_i;
    end
  end

  assign mw[0] = model_c0_r01_i;
  assign mw[1] = model_c0_r23_i;
  assign mw[2] = model_c1_r01_i;
  assign mw[3] = model_c1_r23_i;
  assign mw[4] = model_c2_r01_i;
  assign mw[5] = model_c2_r23_i;
  assign mw[6] = model_c3_r01_i;
  assign mw[7] = model_c3_r23_i;

  always_comb begin
    for (int c = 0; c < NUM_ROWS; c++) begin
      vp[0][c] = vp_q[2*c][W-1:0];
      vp[1][c] = vp_q[2*c][HALF_W +: W];
      vp[2][c] = vp_q[2*c+1][W-1:0];
      vp[3][c] = vp_q[2*c+1][HALF_W +: W];
      md[0][c] = mw[2*c][W-1:0];
      md[1][c] = mw[2*c][HALF_W +: W];
      md[2][c] = mw[2*c+1][W-1:0];
      md[3][c] = mw[2*c+1][HALF_W +: W];
    end
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_ROWS; c++) begin
        for (int k = 0; k < NUM_ROWS; k++) begin
          prod_d[r][c][k] = vp[r][k] * md[k][c];
        end
      end
    end
  end

  assign org[0] = origin_xy_i[W-1:0];
  assign org[1] = origin_xy_i[HALF_W +: W];
  assign org[2] = origin_z_extent_x_i[W-1:0];
  assign ext[0] = origin_z_extent_x_i[HALF_W +: W];
  assign ext[1] = extent_yz_i[W-1:0];
  assign ext[2] = extent_yz_i[HALF_W +: W];

  // Corner coordinates saturate to the coordinate range.
  always_comb begin
    logic signed [W:0] sp;
    logic signed [W:0] sn;
    sp = '0;
    sn = '0;
    for (int k = 0; k < NUM_AXES; k++) begin
      sp = (W+1)'(org[k]) + (W+1)'(ext[k]);
      sn = (W+1)'(org[k]) - (W+1)'(ext[k]);
      pos_d[k] = (sp[W] != sp[W-1]) ? {sp[W], {(W-1){~sp[W]}}} : sp[W-1:0];
      neg_d[k] = (sn[W] != sn[W-1]) ? {sn[W], {(W-1){~sn[W]}}} : sn[W-1:0];
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_ROWS; c++) begin
        sum_d[r][c] = SW'(prod_q[r][c][0]) + SW'(prod_q[r][c][1])
                    + SW'(prod_q[r][c][2]) + SW'(prod_q[r][c][3]);
      end
    end
  end

  // Floor toward minus infinity, then saturate the combined matrix entry.
  always_comb begin
    logic signed [SW-1:0] sh;
    sh = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_ROWS; c++) begin
        sh = sum_q[r][c] >>> FRAC_BITS;
        if (sh > $signed({{(W+3){1'b0}}, {(W-1){1'b1}}})) begin
          cm_d[r][c] = {1'b0, {(W-1){1'b1}}};
        end else if (sh < $signed({{(W+3){1'b1}}, {(W-1){1'b0}}})) begin
          cm_d[r][c] = {1'b1, {(W-1){1'b0}}};
        end else begin
          cm_d[r][c] = sh[W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], start};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    sum_q    <= sum_d;
    cm_q     <= cm_d;
    pos_q[0] <= pos_d;
    neg_q[0] <= neg_d;
    pos_q[1] <= pos_q[0];
    neg_q[1] <= neg_q[0];
    pos_q[2] <= pos_q[1];
    neg_q[2] <= neg_q[1];
  end

  bfc_corner_test #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_corner_test (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_q[2]),
    .cm_i             (cm_q),
    .pos_i            (pos_q[2]),
    .neg_i            (neg_q[2]),
    .valid_o          (result_valid_o),
    .visible_o        (visible_o),
    .near_plane_hit_o (near_plane_hit_o)
  );

endmodule
